FILE: rtl/brms_pkg.sv
// Shared types and constants of the block RMS level meter.
// Holds field widths, register indexes, saturation limits and the lane status struct.
// No dependencies.
package brms_pkg;

    // field and datapath widths
    localparam int SAMPLE_W   = 24;
    localparam int LEVEL_W    = 16;
    localparam int N_W        = 11;
    localparam int SUM_W      = 57;
    localparam int QUO_W      = SUM_W + 2;
    localparam int ROOT_W     = LEVEL_W + 1;
    localparam int SREM_W     = ROOT_W + 3;
    localparam int CFG_ADDR_W = 2;

    // stream payload widths
    localparam int S_DATA_W = 2 * SAMPLE_W;
    localparam int M_DATA_W = 2 * LEVEL_W;
    localparam int M_USER_W = 4;

    // parameter defaults
    localparam int MAX_BLOCK_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LEFT_EN   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_EN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_LEN = 2'd2;

    // saturation limits
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = {LEVEL_W{1'b1}};
    localparam logic [SUM_W-1:0]   LEVEL_SQ_MAX = SUM_W'(64'd4294836225);

    // status of one lane as seen by the merge stage
    typedef struct packed {
        logic               busy;
        logic               done;
        logic               valid;
        logic               clipped;
        logic [LEVEL_W-1:0] level;
    } brms_lane_stat_t;

endpackage

FILE: rtl/block_rms_level_meter.sv
// Top level of the two-channel block RMS level meter.
// Holds configuration, block counter, the two lanes and the output register.
// Depends on brms_pkg and brms_lane.
//
// Usage:
//   Samples enter on the s_axis channel, one left and one right sample per
//   transfer. Within a block one transfer is taken every cycle. After the
//   block's last transfer each lane divides four times its sum of squares by
//   the block length (59 one-bit steps) and takes a 17-step digit square
//   root; both lanes run in lockstep. s_axis_tready is low from the cycle
//   after the block's last sample transfer until the result moves into the
//   output register.
//   The output register holds a result while m_axis_tready is low; a new
//   block is accepted meanwhile, but the next result waits in the lanes and
//   holds off input until the register frees.
//   Reset clears the sums, the block count and the output valid; both
//   channels come up disabled with a block length of one.
//   Configuration is written through cfg_we, cfg_addr and cfg_wdata.
module block_rms_level_meter #(
    parameter int MAX_BLOCK   = brms_pkg::MAX_BLOCK_DEF,
    parameter int SAMPLE_BITS = brms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [brms_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [brms_pkg::N_W-1:0]           cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // left_sample [23:0], right_sample [47:24]
    input  logic [brms_pkg::S_DATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // left_level [15:0], right_level [31:16]
    output logic [brms_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // left_valid [0], left_clipped [1], right_valid [2], right_clipped [3]
    output logic [brms_pkg::M_USER_W-1:0]      m_axis_tuser
);
    import brms_pkg::*;

    logic                  left_en_reg;
    logic                  right_en_reg;
    logic [N_W-1:0]        blen_reg;
    logic [N_W-1:0]        cnt_reg;
    logic [N_W-1:0]        cnt_next;
    logic [N_W-1:0]        n_eff;
    logic [N_W:0]          cnt_inc;
    logic                  blk_last;
    logic                  s_xfer;
    logic                  load;
    logic                  m_valid_reg;
    logic [M_DATA_W-1:0]   m_data_reg;
    logic [M_USER_W-1:0]   m_user_reg;
    brms_lane_stat_t       stat_l;
    brms_lane_stat_t       stat_r;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_en_reg  <= 1'b0;
            right_en_reg <= 1'b0;
            blen_reg     <= N_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_LEFT_EN:   left_en_reg  <= cfg_wdata[0];
                REG_RIGHT_EN:  right_en_reg <= cfg_wdata[0];
                REG_BLOCK_LEN: blen_reg     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // effective block length, zero taken as one and clamped to the maximum
    always_comb
    begin
        if (blen_reg == '0)
            n_eff = N_W'(1);
        else if (int'(blen_reg) > MAX_BLOCK)
            n_eff = N_W'(MAX_BLOCK);
        else
            n_eff = blen_reg;
    end

    // input handshake and block counter
    assign s_axis_tready = ~stat_l.busy & ~stat_r.busy;
    assign s_xfer        = s_axis_tvalid & s_axis_tready;
    assign cnt_inc       = {1'b0, cnt_reg} + (N_W + 1)'(1);
    assign blk_last      = cnt_inc >= {1'b0, n_eff};
    assign cnt_next      = blk_last ? '0 : cnt_inc[N_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (s_xfer)
            cnt_reg <= cnt_next;
    end

    // lanes
    brms_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_l (
        .clk    (clk),
        .rst_n  (rst_n),
        .xfer   (s_xfer),
        .en     (left_en_reg),
        .last   (blk_last),
        .sample (s_axis_tdata[SAMPLE_BITS-1:0]),
        .n      (n_eff),
        .ack    (load),
        .stat   (stat_l)
    );

    brms_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_r (
        .clk    (clk),
        .rst_n  (rst_n),
        .xfer   (s_xfer),
        .en     (right_en_reg),
        .last   (blk_last),
        .sample (s_axis_tdata[SAMPLE_W +: SAMPLE_BITS]),
        .n      (n_eff),
        .ack    (load),
        .stat   (stat_r)
    );

    // merge lane results into the output register
    assign load = stat_l.done & (~m_valid_reg | m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_data_reg <= {stat_r.level, stat_l.level};
            m_user_reg <= {stat_r.clipped, stat_r.valid, stat_l.clipped, stat_l.valid};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // both lanes run the same fixed step count and must finish together
    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        stat_l.done == stat_r.done)
        else $error("lanes finished out of step");

    // the block's last transfer must hold off input while the level is worked out
    a_hold_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_xfer && blk_last |=> !s_axis_tready)
        else $error("input taken during level computation");

    // a result only appears after the lanes reported done
    a_load_from_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(stat_l.done))
        else $error("output valid without a finished level");
`endif

endmodule

FILE: rtl/brms_root.sv
// Level unit of one lane: restoring divide of 4*sum by the block length,
// then a digit-by-digit square root and rounding to the level.
// Depends on brms_pkg.
module brms_root (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [brms_pkg::SUM_W-1:0]    sum,
    input  logic [brms_pkg::N_W-1:0]      n,
    input  logic                          ack,
    output logic                          idle,
    output logic                          done,
    output logic [brms_pkg::LEVEL_W-1:0]  level,
    output logic                          clipped
);
    import brms_pkg::*;

    localparam int STEP_W = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUO_W - 1);
    localparam logic [STEP_W-1:0] SQ_LAST  = STEP_W'(ROOT_W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [N_W-1:0]    n_reg;
    logic [N_W-1:0]    rem_reg;
    logic [QUO_W-1:0]  dq_reg;
    logic [ROOT_W-1:0] rt_reg;
    logic [SREM_W-1:0] sr_reg;
    logic              clip_reg;

    logic [N_W:0]      div_sh;
    logic [N_W:0]      div_dif;
    logic              div_ge;
    logic [SREM_W-1:0] sq_sh;
    logic [SREM_W-1:0] sq_trial;
    logic [SREM_W-1:0] sq_dif;
    logic              sq_ge;
    logic [ROOT_W:0]   rnd;
    logic              over_max;

    // one quotient bit per divide step
    assign div_sh  = {rem_reg, dq_reg[QUO_W-1]};
    assign div_ge  = div_sh >= {1'b0, n_reg};
    assign div_dif = div_sh - {1'b0, n_reg};

    // sum above n*LEVEL_MAX^2: 4*sum/n strictly above 4*LEVEL_MAX^2, remainder included
    assign over_max = (dq_reg[QUO_W-1:2] > LEVEL_SQ_MAX) ||
                      ((dq_reg[QUO_W-1:2] == LEVEL_SQ_MAX) &&
                       ((dq_reg[1:0] != 2'b00) || (rem_reg != '0)));

    // one root bit per square root step, two quotient bits brought down
    assign sq_sh    = {sr_reg[SREM_W-3:0], dq_reg[2*ROOT_W-1 -: 2]};
    assign sq_trial = {1'b0, rt_reg, 2'b01};
    assign sq_ge    = sq_sh >= sq_trial;
    assign sq_dif   = sq_sh - sq_trial;

    // largest odd m with m*m <= q is isqrt(q) or one less, level is (isqrt+1)/2
    assign rnd = {1'b0, rt_reg} + (ROOT_W + 1)'(1);

    assign idle    = (state_reg == ST_IDLE);
    assign done    = (state_reg == ST_DONE);
    assign level   = clip_reg ? LEVEL_MAX : rnd[LEVEL_W:1];
    assign clipped = clip_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (start)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_CHK;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_CHK:
                state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (step_reg == SQ_LAST)
                begin
                    state_next = ST_DONE;
                    step_next  = '0;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_DONE:
            begin
                if (ack)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_reg   <= n;
                    rem_reg <= '0;
                    dq_reg  <= {sum, 2'b00};
                end
            end
            ST_DIV:
            begin
                dq_reg  <= {dq_reg[QUO_W-2:0], div_ge};
                rem_reg <= div_ge ? div_dif[N_W-1:0] : div_sh[N_W-1:0];
            end
            ST_CHK:
            begin
                clip_reg <= over_max;
                rt_reg   <= '0;
                sr_reg   <= '0;
            end
            ST_SQRT:
            begin
                sr_reg <= sq_ge ? sq_dif : sq_sh;
                rt_reg <= {rt_reg[ROOT_W-2:0], sq_ge};
                dq_reg <= {dq_reg[QUO_W-3:0], 2'b00};
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: rtl/brms_lane.sv
// One measurement lane: magnitude squarer, sum of squares and its level unit.
// Depends on brms_pkg and brms_root.
module brms_lane #(
    parameter int SAMPLE_BITS = brms_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           xfer,
    input  logic                           en,
    input  logic                           last,
    input  logic [SAMPLE_BITS-1:0]         sample,
    input  logic [brms_pkg::N_W-1:0]       n,
    input  logic                           ack,
    output brms_pkg::brms_lane_stat_t      stat
);
    import brms_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0] mag;
    logic [SQ_W-1:0]        prod;
    logic [SQ_W-1:0]        sq_reg;
    logic                   sq_vld_reg;
    logic                   sq_last_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic                   valid_reg;
    logic                   start;
    logic                   root_idle;
    logic                   root_done;
    logic [LEVEL_W-1:0]     root_level;
    logic                   root_clipped;

    // magnitude and square of the sample
    assign mag  = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
    assign prod = SQ_W'(mag) * SQ_W'(mag);

    always_ff @(posedge clk)
    begin
        if (xfer)
            sq_reg <= en ? prod : '0;
    end

    // square stage control and enable captured with the block's last item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg  <= 1'b0;
            sq_last_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            sq_vld_reg  <= xfer;
            sq_last_reg <= xfer & last;
            if (xfer && last)
                valid_reg <= en;
        end
    end

    // accumulate, clear at block end
    assign sum_next = sum_reg + SUM_W'(sq_reg);
    assign start    = sq_vld_reg & sq_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else if (sq_vld_reg)
            sum_reg <= sq_last_reg ? '0 : sum_next;
    end

    brms_root u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .sum     (sum_next),
        .n       (n),
        .ack     (ack),
        .idle    (root_idle),
        .done    (root_done),
        .level   (root_level),
        .clipped (root_clipped)
    );

    // status toward the merge stage, disabled lane reads as zero
    always_comb
    begin
        stat.busy    = start | ~root_idle;
        stat.done    = root_done;
        stat.valid   = valid_reg;
        stat.clipped = valid_reg & root_clipped;
        stat.level   = valid_reg ? root_level : '0;
    end

endmodule

FILE: verif/brms_checker.sv
// Checker for the block RMS level meter: watches the config port and both streams.
// Predicts each block's levels from accepted samples and compares every output transfer.
// Depends on brms_pkg.
module brms_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [brms_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [brms_pkg::N_W-1:0]        cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [brms_pkg::S_DATA_W-1:0]   s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [brms_pkg::M_DATA_W-1:0]   m_axis_tdata,
    input  logic [brms_pkg::M_USER_W-1:0]   m_axis_tuser,
    output int                              fail_count,
    output int                              outstanding,
    output int                              levels_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import brms_pkg::*;

    localparam int MAX_REPORTS = 10;

    // one result as it leaves the block
    typedef struct packed {
        logic [LEVEL_W-1:0] left_level;
        logic               left_valid;
        logic               left_clipped;
        logic [LEVEL_W-1:0] right_level;
        logic               right_valid;
        logic               right_clipped;
    } level_report_t;

    // predictor copy of the registers and the running block
    bit             left_on;
    bit             right_on;
    bit [N_W-1:0]   block_len;
    bit [SUM_W-1:0] left_energy;
    bit [SUM_W-1:0] right_energy;
    int unsigned    block_fill;

    level_report_t  expected_levels[$];

    initial begin
        fail_count     = 0;
        outstanding    = 0;
        levels_checked = 0;
    end

    // square of a signed sample, taken through its magnitude
    function automatic bit [63:0] squared(input logic [SAMPLE_W-1:0] value);
        bit [SAMPLE_W-1:0] mag;
        mag = value[SAMPLE_W-1] ? ~value + 1'b1 : value;
        return 64'(mag) * 64'(mag);
    endfunction

    // block length as the block applies it
    function automatic bit [63:0] items_per_block(input bit [N_W-1:0] len);
        if (len == 0)
            return 64'd1;
        if (len > MAX_BLOCK_DEF)
            return 64'(MAX_BLOCK_DEF);
        return 64'(len);
    endfunction

    // rounded rms of one channel: {clipped, level}
    function automatic bit [LEVEL_W:0] rounded_rms(input bit [63:0] energy, input bit [63:0] n);
        bit [63:0] root;
        bit [63:0] trial;
        bit [63:0] odd;
        bit [63:0] four_energy;
        if (energy > n * 64'(LEVEL_MAX) * 64'(LEVEL_MAX))
            return {1'b1, LEVEL_MAX};
        four_energy = energy << 2;
        root = 0;
        // largest r with n*(2r-1)^2 <= 4*energy, one bit at a time
        for (int b = LEVEL_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            odd   = 2 * trial - 1;
            if (n * odd * odd <= four_energy)
                root = trial;
        end
        return {1'b0, root[LEVEL_W-1:0]};
    endfunction

    // accumulate one accepted sample pair, close the block when full
    function automatic void take_samples(input logic [S_DATA_W-1:0] data);
        bit [63:0]      n;
        bit [LEVEL_W:0] rms;
        level_report_t  report;
        n = items_per_block(block_len);
        if (left_on)
            left_energy = left_energy + SUM_W'(squared(data[SAMPLE_W-1:0]));
        if (right_on)
            right_energy = right_energy + SUM_W'(squared(data[2*SAMPLE_W-1:SAMPLE_W]));
        block_fill++;
        if (block_fill < n)
            return;
        report = '0;
        if (left_on)
        begin
            rms = rounded_rms(64'(left_energy), n);
            report.left_level   = rms[LEVEL_W-1:0];
            report.left_clipped = rms[LEVEL_W];
            report.left_valid   = 1'b1;
        end
        if (right_on)
        begin
            rms = rounded_rms(64'(right_energy), n);
            report.right_level   = rms[LEVEL_W-1:0];
            report.right_clipped = rms[LEVEL_W];
            report.right_valid   = 1'b1;
        end
        expected_levels.push_back(report);
        left_energy  = 0;
        right_energy = 0;
        block_fill   = 0;
    endfunction

    // compare one output transfer against the oldest prediction
    function automatic void check_levels();
        level_report_t want;
        level_report_t got;
        got.left_level    = m_axis_tdata[LEVEL_W-1:0];
        got.right_level   = m_axis_tdata[2*LEVEL_W-1:LEVEL_W];
        got.left_valid    = m_axis_tuser[0];
        got.left_clipped  = m_axis_tuser[1];
        got.right_valid   = m_axis_tuser[2];
        got.right_clipped = m_axis_tuser[3];
        if (expected_levels.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%t: result with no block pending: data %h user %b",
                         $realtime, m_axis_tdata, m_axis_tuser);
            return;
        end
        want = expected_levels.pop_front();
        levels_checked++;
        if (got !== want)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("%t: level mismatch, expected L=%0d v=%0d c=%0d R=%0d v=%0d c=%0d",
                         $realtime, want.left_level, want.left_valid, want.left_clipped,
                         want.right_level, want.right_valid, want.right_clipped);
                $display("%t:                   actual L=%0d v=%0d c=%0d R=%0d v=%0d c=%0d",
                         $realtime, got.left_level, got.left_valid, got.left_clipped,
                         got.right_level, got.right_valid, got.right_clipped);
            end
        end
    endfunction

    // per-edge monitor: register writes, input transfers, output transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            left_on      = 1'b0;
            right_on     = 1'b0;
            block_len    = N_W'(1);
            left_energy  = 0;
            right_energy = 0;
            block_fill   = 0;
            expected_levels.delete();
        end
        else
        begin
            if (cfg_we === 1'b1)
            begin
                case (cfg_addr)
                    REG_LEFT_EN:   left_on   = cfg_wdata[0];
                    REG_RIGHT_EN:  right_on  = cfg_wdata[0];
                    REG_BLOCK_LEN: block_len = cfg_wdata;
                    default:       ;
                endcase
            end
            if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)
                take_samples(s_axis_tdata);
            if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                check_levels();
        end
        outstanding <= expected_levels.size();
    end

endmodule

FILE: verif/testbench.sv
// Top of the block RMS level meter testbench: clock, reset, stimulus and verdict.
// Drives directed and random sample blocks under changing settings and idle mixes.
// Depends on brms_pkg, block_rms_level_meter and brms_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import brms_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int LONG_HOLD     = 1500;
    localparam int GAP_CAP       = 50;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 10;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [N_W-1:0]        cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [M_USER_W-1:0]   m_axis_tuser;

    int fail_count;
    int outstanding;
    int levels_checked;

    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned samples_sent   = 0;

    block_rms_level_meter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    brms_checker level_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .levels_checked (levels_checked)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, outstanding);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus long hold-offs on request
    initial
    begin
        int unsigned holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // random sample, modest keeps the magnitude near the saturation point or below
    function automatic logic [SAMPLE_W-1:0] pick_sample(input bit modest);
        int unsigned       kind;
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] value;
        kind = modest ? $urandom_range(89, 25) : $urandom_range(99);
        if (kind < 25)
            return SAMPLE_W'($urandom());
        else if (kind < 60)
            mag = SAMPLE_W'($urandom_range(70000));
        else if (kind < 80)
            mag = SAMPLE_W'($urandom_range(255));
        else if (kind < 90)
            mag = SAMPLE_W'($urandom_range(65541, 65530));
        else
        begin
            case ($urandom_range(3))
                0:       return 24'h800000;
                1:       return 24'h7FFFFF;
                2:       return '0;
                default: return 24'hFFFFFF;
            endcase
        end
        value = $urandom_range(1) ? -mag : mag;
        return value;
    endfunction

    // offer one sample pair and wait for the transfer, then maybe go idle
    task automatic push_samples(input logic [SAMPLE_W-1:0] left_in,
                                input logic [SAMPLE_W-1:0] right_in);
        int unsigned gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {right_in, left_in};
        @(posedge clk);
        while (s_axis_tready !== 1'b1)
            @(posedge clk);
        samples_sent++;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every predicted result has arrived
    task automatic drain(input bit settle);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write; the caller lowers the enable after a batch
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [N_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic set_config(input bit left_en, input bit right_en, input logic [N_W-1:0] len);
        write_reg(REG_LEFT_EN, {(N_W-1)'($urandom()), left_en});
        write_reg(REG_RIGHT_EN, {(N_W-1)'($urandom()), right_en});
        write_reg(REG_BLOCK_LEN, len);
        cfg_we <= 1'b0;
    endtask

    // idle mix of a phase: none, sender, receiver, both
    task automatic set_idle_mix(input int unsigned mix);
        case (mix % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
            1:       begin send_idle_pct = 82; recv_stall_pct <= 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct <= 82; end
            default: begin send_idle_pct = 25; recv_stall_pct <= 25; end
        endcase
    endtask

    // stimulus and verdict
    initial
    begin
        bit             left_en;
        bit             right_en;
        logic [N_W-1:0] len;
        int unsigned    pick;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both channels disabled at reset, length one
        push_samples(24'h7FFFFF, 24'h800000);
        push_samples(24'd1, 24'd1);
        drain(1);

        // single-item blocks: zero, full scale, saturation edge, sign handling
        set_config(1'b1, 1'b1, N_W'(1));
        push_samples(24'd0, 24'd0);
        push_samples(24'h7FFFFF, 24'h800000);
        push_samples(24'd65535, -24'd65535);
        push_samples(24'd65536, -24'd65536);
        push_samples(24'hFFFFFF, 24'd1);
        push_samples(24'd3, -24'd3);
        push_samples(-24'd100, 24'd200);
        drain(1);

        // length zero acts as one, unused index is ignored
        write_reg(REG_BLOCK_LEN, N_W'(0));
        write_reg(REG_UNUSED, N_W'($urandom()));
        cfg_we <= 1'b0;
        push_samples(24'd100, -24'd200);
        drain(1);

        // rounding on the half boundary, then just below it
        write_reg(REG_BLOCK_LEN, N_W'(4));
        cfg_we <= 1'b0;
        push_samples(24'd1, 24'd2);
        repeat (3) push_samples(24'd0, 24'd0);
        drain(1);
        write_reg(REG_BLOCK_LEN, N_W'(5));
        cfg_we <= 1'b0;
        push_samples(-24'd1, 24'd0);
        repeat (4) push_samples(24'd0, 24'd0);
        drain(1);

        // left channel disabled in the middle of a block
        write_reg(REG_BLOCK_LEN, N_W'(3));
        cfg_we <= 1'b0;
        push_samples(24'd500, 24'd500);
        push_samples(24'd500, -24'd500);
        drain(1);
        write_reg(REG_LEFT_EN, N_W'(0));
        cfg_we <= 1'b0;
        push_samples(24'd500, 24'd500);
        drain(1);

        // length lowered below the items already taken in
        set_config(1'b1, 1'b1, N_W'(4));
        repeat (3) push_samples(pick_sample(1'b1), pick_sample(1'b1));
        drain(1);
        write_reg(REG_BLOCK_LEN, N_W'(2));
        cfg_we <= 1'b0;
        push_samples(pick_sample(1'b1), pick_sample(1'b1));
        drain(1);

        // longest block: a length above the maximum clamps to it
        set_idle_mix(2);
        set_config(1'b1, 1'b1, N_W'(2047));
        repeat (MAX_BLOCK_DEF) push_samples(pick_sample(1'b0), pick_sample(1'b0));
        drain(1);

        // output held off while input keeps coming, so the block backs up
        set_idle_mix(0);
        set_config(1'b1, 1'b1, N_W'(1));
        hold_requests <= hold_requests + 1;
        repeat (30) push_samples(pick_sample(1'b0), pick_sample(1'b1));
        drain(1);

        // random phases, settings change with partial blocks left in flight
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_idle_mix(ph);
            left_en  = ($urandom_range(3) != 0);
            right_en = ($urandom_range(3) != 0);
            pick = $urandom_range(19);
            if (pick == 0)
                len = N_W'(0);
            else if (pick == 1)
                len = N_W'($urandom_range(64, 17));
            else
                len = N_W'($urandom_range(16, 1));
            set_config(left_en, right_en, len);
            if ($urandom_range(3) == 0)
            begin
                write_reg(REG_UNUSED, N_W'($urandom()));
                cfg_we <= 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender pause until the block has delivered everything
                if (ph == 5 && i == PHASE_ITEMS / 2)
                    drain(0);
                push_samples(pick_sample(1'b0), pick_sample(1'b0));
            end
            drain(1);
        end

        set_idle_mix(0);
        drain(1);

        $display("covered %0d sample transfers and %0d level results over %0d random phases",
                 samples_sent, levels_checked, NUM_PHASES);
        $display("block lengths 0 to 2047, enables toggled mid-block, idle mixes, long stall");
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: block_rms_level_meter.f
rtl/brms_pkg.sv
rtl/brms_root.sv
rtl/brms_lane.sv
rtl/block_rms_level_meter.sv
verif/brms_checker.sv
verif/testbench.sv
